>>> rtl/core/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// shared types and constants for the sorted free-list allocator
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int ADDR_BITS    = 32;
    localparam int IDX_BITS     = $clog2(FREE_ENTRIES);
    localparam int CNT_BITS     = $clog2(FREE_ENTRIES + 1);
    localparam int ENT_BITS     = 2 * ADDR_BITS;

    localparam logic [ADDR_BITS-1:0] PAGE_LOW = ADDR_BITS'(12'hfff);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] region_address;
        logic [31:0] region_size;
    } in_word_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] granted_address;
        logic [6:0]  entry_count;
        logic [6:0]  peak_entries;
        logic [31:0] lost_frees;
        logic [31:0] lost_bytes;
    } out_word_t;

endpackage

>>> rtl/core/sfla_ram.sv
// ----------------------------------------------------------------------------
// sfla_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module sfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/sorted_free_list_allocator.sv
// ----------------------------------------------------------------------------
// sorted_free_list_allocator
// address-sorted free-region table with carve, exact-fit and coalescing free
// ----------------------------------------------------------------------------
// Requests arrive as one word on in_valid/in_stall (opcode, region_address,
// region_size); results leave as one word on out_valid/out_stall. One word
// is handled at a time: in_stall is high from acceptance until the result
// word has been taken. The table lives in one ram (start and end packed in
// one entry) with a registered read, so each step of a scan passes through
// a read state (S_RD) and a compare state (S_CMP); inserting or removing an
// entry then moves each shifted entry through S_SHRD and S_SHWR. Reset
// empties the table (count zero) and clears peak and lost statistics; no
// clearing pass is needed since only entries below the count are read.
// page_round is written through cfg_we/cfg_data; the user must write it only
// while idle, as the block itself does not enforce this. If the receiver
// stalls, the result word holds on out_word and no new request is taken.
// ----------------------------------------------------------------------------
module sorted_free_list_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sfla_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sfla_pkg::out_word_t  out_word
);

    localparam int AB = sfla_pkg::ADDR_BITS;
    localparam int IB = sfla_pkg::IDX_BITS;
    localparam int CB = sfla_pkg::CNT_BITS;
    localparam int EB = sfla_pkg::ENT_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_CMP   = 9'b000000100,
        S_NXTRD = 9'b000001000,
        S_NXT   = 9'b000010000,
        S_SHRD  = 9'b000100000,
        S_SHWR  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    // shift kinds
    localparam logic SH_DROP = 1'b0;
    localparam logic SH_INS  = 1'b1;

    state_t          state_reg, state_next;
    logic            page_reg;
    logic [CB-1:0]   count_reg, count_next;
    logic [CB-1:0]   peak_reg, peak_next;
    logic [31:0]     lcnt_reg, lcnt_next;
    logic [31:0]     ltot_reg, ltot_next;
    logic            op_reg, op_next;
    logic [AB-1:0]   addr_reg, addr_next;
    logic [AB-1:0]   size_reg, size_next;
    logic [CB-1:0]   pos_reg, pos_next;
    logic            found_reg, found_next;
    logic [CB-1:0]   mark_reg, mark_next;
    logic            ok_reg, ok_next;
    logic [AB-1:0]   gr_reg, gr_next;
    logic [AB-1:0]   pend_reg, pend_next;     // merged start for bridging free
    logic            shk_reg, shk_next;
    logic [CB-1:0]   shi_reg, shi_next;       // shift cursor
    logic [CB-1:0]   shstop_reg, shstop_next;
    logic [EB-1:0]   ins_reg, ins_next;       // entry to place at end of insert

    logic            we;
    logic [IB-1:0]   waddr, raddr;
    logic [EB-1:0]   wdata, rdata;

    logic [AB-1:0]   r_start, r_end, r_len, f_end, rsize;

    sfla_ram #(.WIDTH(EB), .DEPTH(sfla_pkg::FREE_ENTRIES)) u_tab (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign r_start = rdata[EB-1:AB];
    assign r_end   = rdata[AB-1:0];
    assign r_len   = r_end - r_start;
    assign f_end   = addr_reg + size_reg;
    assign rsize   = page_reg ? ((AB'(in_word.region_size) + sfla_pkg::PAGE_LOW)
                                 & ~sfla_pkg::PAGE_LOW)
                              : AB'(in_word.region_size);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        out_word                 = '0;
        out_word.ok              = ok_reg;
        out_word.granted_address = gr_reg[31:0];
        out_word.entry_count     = 7'(count_reg);
        out_word.peak_entries    = 7'(peak_reg);
        out_word.lost_frees      = lcnt_reg;
        out_word.lost_bytes      = ltot_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        peak_next   = peak_reg;
        lcnt_next   = lcnt_reg;
        ltot_next   = ltot_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        mark_next   = mark_reg;
        ok_next     = ok_reg;
        gr_next     = gr_reg;
        pend_next   = pend_reg;
        shk_next    = shk_reg;
        shi_next    = shi_reg;
        shstop_next = shstop_reg;
        ins_next    = ins_reg;
        we          = 1'b0;
        waddr       = pos_reg[IB-1:0];
        wdata       = rdata;
        raddr       = pos_reg[IB-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_word.opcode;
                    addr_next  = AB'(in_word.region_address);
                    size_next  = rsize;
                    pos_next   = '0;
                    found_next = 1'b0;
                    mark_next  = '0;
                    ok_next    = 1'b0;
                    gr_next    = '0;
                    if (in_word.opcode == sfla_pkg::OP_FREE && page_reg
                        && in_word.region_address == 32'd0)
                    begin
                        ok_next    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (pos_reg < count_reg)
                begin
                    state_next = S_CMP;
                end
                else if (op_reg == sfla_pkg::OP_ALLOC)
                begin
                    if (found_reg)
                    begin
                        pos_next   = mark_reg;
                        state_next = S_NXTRD;   // re-read marked entry for grant
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_FIN;          // insert at pos
                end
            end
            S_CMP:
            begin
                if (op_reg == sfla_pkg::OP_ALLOC)
                begin
                    if (r_len > size_reg)
                    begin
                        ok_next    = 1'b1;
                        gr_next    = r_start;
                        we         = 1'b1;
                        wdata      = {r_start + size_reg, r_end};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (!found_reg && r_len == size_reg)
                        begin
                            found_next = 1'b1;
                            mark_next  = pos_reg;
                        end
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (r_end < addr_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (r_end == addr_reg)
                begin
                    ok_next   = 1'b1;
                    we        = 1'b1;
                    wdata     = {r_start, f_end};
                    pend_next = r_start;
                    if (pos_reg + 1'b1 < count_reg)
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_NXTRD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (r_start < f_end)
                begin
                    lcnt_next  = lcnt_reg + 32'd1;
                    ltot_next  = ltot_reg + size_reg[31:0];
                    state_next = S_OUT;
                end
                else if (f_end == r_start)
                begin
                    ok_next    = 1'b1;
                    we         = 1'b1;
                    wdata      = {addr_reg, r_end};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_NXTRD:
            begin
                state_next = S_NXT;             // read of pos issued
            end
            S_NXT:
            begin
                if (op_reg == sfla_pkg::OP_ALLOC)
                begin
                    ok_next     = 1'b1;
                    gr_next     = r_start;
                    shk_next    = SH_DROP;
                    shi_next    = pos_reg;
                    shstop_next = count_reg - 1'b1;
                    count_next  = count_reg - 1'b1;
                    state_next  = S_SHRD;
                end
                else if (f_end == r_start)
                begin
                    // bridge: prior entry becomes {pend, r_end}, drop pos
                    we          = 1'b1;
                    waddr       = IB'(pos_reg - 1'b1);
                    wdata       = {pend_reg, r_end};
                    shk_next    = SH_DROP;
                    shi_next    = pos_reg;
                    shstop_next = count_reg - 1'b1;
                    count_next  = count_reg - 1'b1;
                    state_next  = S_SHRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SHRD:
            begin
                // drop: move shi+1 -> shi while shi < stop
                // insert: move shi-1 -> shi while shi > stop
                if (shk_reg == SH_DROP)
                begin
                    if (shi_reg < shstop_reg)
                    begin
                        raddr      = IB'(shi_reg + 1'b1);
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    if (shi_reg > shstop_reg)
                    begin
                        raddr      = IB'(shi_reg - 1'b1);
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = shstop_reg[IB-1:0];
                        wdata      = ins_reg;
                        state_next = S_OUT;
                    end
                end
            end
            S_SHWR:
            begin
                we    = 1'b1;
                waddr = shi_reg[IB-1:0];
                wdata = rdata;
                if (shk_reg == SH_DROP)
                begin
                    shi_next = shi_reg + 1'b1;
                end
                else
                begin
                    shi_next = shi_reg - 1'b1;
                end
                state_next = S_SHRD;
            end
            S_FIN:
            begin
                if (count_reg >= CB'(sfla_pkg::FREE_ENTRIES))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ok_next     = 1'b1;
                    ins_next    = {addr_reg, f_end};
                    shk_next    = SH_INS;
                    shi_next    = count_reg;
                    shstop_next = pos_reg;
                    count_next  = count_reg + 1'b1;
                    if (count_reg + 1'b1 > peak_reg)
                    begin
                        peak_next = count_reg + 1'b1;
                    end
                    state_next  = S_SHRD;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            page_reg  <= 1'b0;
            count_reg <= '0;
            peak_reg  <= '0;
            lcnt_reg  <= '0;
            ltot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
            lcnt_reg  <= lcnt_next;
            ltot_reg  <= ltot_next;
            if (cfg_we)
            begin
                page_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        size_reg   <= size_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        mark_reg   <= mark_next;
        ok_reg     <= ok_next;
        gr_reg     <= gr_next;
        pend_reg   <= pend_next;
        shk_reg    <= shk_next;
        shi_reg    <= shi_next;
        shstop_reg <= shstop_next;
        ins_reg    <= ins_next;
    end

endmodule

>>> test/sorted_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// sorted_free_list_allocator_test
// drives alloc and free words with random gaps and stalls, and checks every
// result word against a behavioral copy of the sorted free-region table
// ----------------------------------------------------------------------------
class alloc_scoreboard;
    logic [31:0] starts [64];
    logic [31:0] ends_q [64];
    int          count;
    int          peak;
    logic [31:0] lost_n;
    logic [31:0] lost_b;
    bit          page_mode;
    sfla_pkg::out_word_t pending [$];
    int          errors;
    int          checked;

    function void clear();
        count = 0;
        peak = 0;
        lost_n = 0;
        lost_b = 0;
        page_mode = 0;
        errors = 0;
        checked = 0;
        pending.delete();
    endfunction

    function void remove_at(int pos);
        for (int k = pos; k + 1 < count; k++)
        begin
            starts[k] = starts[k+1];
            ends_q[k] = ends_q[k+1];
        end
        if (count > 0)
            count--;
    endfunction

    function bit release_region(logic [31:0] s, logic [31:0] sz);
        logic [31:0] e;
        int pos;
        e = s + sz;
        pos = 0;
        for (; pos < count; pos++)
        begin
            if (ends_q[pos] < s)
                continue;
            if (ends_q[pos] == s)
            begin
                ends_q[pos] = e;
                if (pos + 1 < count && e == starts[pos+1])
                begin
                    ends_q[pos] = ends_q[pos+1];
                    remove_at(pos + 1);
                end
                return 1;
            end
            if (starts[pos] < e)
            begin
                lost_b += sz;
                lost_n += 1;
                return 0;
            end
            if (e == starts[pos])
            begin
                starts[pos] = s;
                return 1;
            end
            break;
        end
        if (count >= 64)
            return 0;
        for (int k = count; k > pos; k--)
        begin
            starts[k] = starts[k-1];
            ends_q[k] = ends_q[k-1];
        end
        starts[pos] = s;
        ends_q[pos] = e;
        count++;
        if (count > peak)
            peak = count;
        return 1;
    endfunction

    function bit carve(logic [31:0] sz, output logic [31:0] g);
        int mark;
        bit found;
        logic [31:0] len;
        mark = 0;
        found = 0;
        g = 0;
        for (int k = 0; k < count; k++)
        begin
            len = ends_q[k] - starts[k];
            if (!found && len == sz)
            begin
                mark = k;
                found = 1;
            end
            if (len > sz)
            begin
                g = starts[k];
                starts[k] = starts[k] + sz;
                return 1;
            end
        end
        if (!found)
            return 0;
        g = starts[mark];
        remove_at(mark);
        return 1;
    endfunction

    function void note_request(sfla_pkg::in_word_t w);
        sfla_pkg::out_word_t r;
        logic [31:0] sz;
        logic [31:0] g;
        bit okv;
        sz = w.region_size;
        g = 0;
        if (page_mode)
            sz = (sz + 32'hfff) & ~32'hfff;
        if (w.opcode == sfla_pkg::OP_ALLOC)
        begin
            okv = carve(sz, g);
            if (!okv)
                g = 0;
        end
        else if (page_mode && w.region_address == 0)
            okv = 1;
        else
            okv = release_region(w.region_address, sz);
        r.ok = okv;
        r.granted_address = g;
        r.entry_count = 7'(count);
        r.peak_entries = 7'(peak);
        r.lost_frees = lost_n;
        r.lost_bytes = lost_b;
        pending.push_back(r);
    endfunction

    function void check_result(sfla_pkg::out_word_t a);
        sfla_pkg::out_word_t x;
        checked++;
        if (pending.size() == 0)
        begin
            $error("result word with nothing expected");
            errors++;
            return;
        end
        x = pending.pop_front();
        if (a.ok !== x.ok)
        begin
            $error("ok: expected %0d got %0d", x.ok, a.ok);
            errors++;
        end
        if (a.granted_address !== x.granted_address)
        begin
            $error("granted_address: expected %h got %h", x.granted_address,
                   a.granted_address);
            errors++;
        end
        if (a.entry_count !== x.entry_count)
        begin
            $error("entry_count: expected %0d got %0d", x.entry_count, a.entry_count);
            errors++;
        end
        if (a.peak_entries !== x.peak_entries)
        begin
            $error("peak_entries: expected %0d got %0d", x.peak_entries,
                   a.peak_entries);
            errors++;
        end
        if (a.lost_frees !== x.lost_frees)
        begin
            $error("lost_frees: expected %0d got %0d", x.lost_frees, a.lost_frees);
            errors++;
        end
        if (a.lost_bytes !== x.lost_bytes)
        begin
            $error("lost_bytes: expected %h got %h", x.lost_bytes, a.lost_bytes);
            errors++;
        end
    endfunction
endclass

module sorted_free_list_allocator_test;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_data;
    logic                in_valid;
    logic                in_stall;
    sfla_pkg::in_word_t  in_word;
    logic                out_valid;
    logic                out_stall;
    sfla_pkg::out_word_t out_word;

    alloc_scoreboard board;
    bit        quiet_phase;
    int        idle_cycles;
    int        sent;

    sorted_free_list_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        board = new();
        board.clear();
    end

    // receiver side: random stall, check each accepted result word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                board.check_result(out_word);
            out_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 19);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** sorted_free_list_allocator: FAILED **");
            $finish;
        end
    end

    task automatic send_word(logic op, logic [31:0] a, logic [31:0] s);
        if (!quiet_phase)
            while ($urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_word <= '{opcode: op, region_address: a, region_size: s};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request('{opcode: op, region_address: a, region_size: s});
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_page_round(bit v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.page_mode = v;
    endtask

    // mostly small sizes in a compact address window so regions interact
    task automatic random_word(int window);
        logic [31:0] a;
        logic [31:0] s;
        int pick;
        pick = $urandom_range(99);
        a = $urandom_range(window) * 16;
        s = $urandom_range(8) * 16;
        if (pick < 5)
            a = $urandom();
        if (pick >= 5 && pick < 10)
            s = $urandom();
        if (pick >= 10 && pick < 13)
            s = 0;
        send_word(1'($urandom_range(1)), a, s);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        quiet_phase = 1'b0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty alloc, inserts, merges, bridge, overlap, exact fit
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'h10);
        send_word(sfla_pkg::OP_FREE, 32'h100, 32'h100);
        send_word(sfla_pkg::OP_FREE, 32'h300, 32'h100);
        send_word(sfla_pkg::OP_FREE, 32'h200, 32'h100);
        send_word(sfla_pkg::OP_FREE, 32'h250, 32'h10);
        send_word(sfla_pkg::OP_FREE, 32'h80, 32'h80);
        send_word(sfla_pkg::OP_ALLOC, 32'hffffffff, 32'h40);
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'h0);
        send_word(sfla_pkg::OP_FREE, 32'h1000, 32'h0);
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'h0);
        send_word(sfla_pkg::OP_FREE, 32'hfffffff0, 32'h20);
        send_word(sfla_pkg::OP_FREE, 32'hffffffff, 32'hffffffff);
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'hffffffff);
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'h2c0);
        send_word(sfla_pkg::OP_FREE, 32'h0, 32'h10);
        // fill the table to its limit
        for (int k = 0; k < 66; k++)
            send_word(sfla_pkg::OP_FREE, 32'h10000 + k * 32, 32'h10);

        set_page_round(1'b1);
        send_word(sfla_pkg::OP_FREE, 32'h0, 32'h5);
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'h1);
        send_word(sfla_pkg::OP_ALLOC, 32'h0, 32'hfffff001);
        send_word(sfla_pkg::OP_FREE, 32'h4000, 32'hffffffff);
        set_page_round(1'b0);

        // random phases with several settings, one long stretch with no idling
        for (int phase = 0; phase < 6; phase++)
        begin
            set_page_round(phase % 3 == 1);
            quiet_phase = (phase == 2);
            for (int n = 0; n < 300; n++)
                random_word(phase == 4 ? 4000 : 64);
            quiet_phase = 1'b0;
        end
        drain();

        $display("covered %0d request words, %0d results checked, page rounding on and off",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("** sorted_free_list_allocator: PASSED **");
        else
            $display("** sorted_free_list_allocator: FAILED **");
        $finish;
    end
endmodule
